/* hdl/windowed_presence_vote_alarm_assert.svh */
// ----------------------------------------------------------------------------
// windowed presence vote alarm assertion macros
// shared assertion forms, clocked on clk and disabled while in reset
// ----------------------------------------------------------------------------
`ifndef WINDOWED_PRESENCE_VOTE_ALARM_ASSERT_SVH
`define WINDOWED_PRESENCE_VOTE_ALARM_ASSERT_SVH

// condition holds at every edge outside reset
`define WPVA_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("wpva assertion failed");

// trigger at one edge implies the outcome at the next edge
`define WPVA_ASSERT_NEXT(lbl, trig, outcome) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
        else $error("wpva assertion failed");

`endif

/* hdl/wpva_pkg.sv */
// ----------------------------------------------------------------------------
// wpva_pkg
// shared types, register indexes, status codes and widths of the vote alarm
// ----------------------------------------------------------------------------
package wpva_pkg;

    localparam int WINDOW_MAX_DEF = 1024;

    localparam int WLEN_W   = 11;
    localparam int RATIO_W  = 17;
    localparam int COOL_W   = 9;
    localparam int CLASS_W  = 16;
    localparam int STATUS_W = 2;
    localparam int TALLY_W  = 2;
    localparam int RATIO_FRAC_W = 16;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic [WLEN_W-1:0]  WLEN_RESET  = 11'd100;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 17'd52429;
    localparam logic [COOL_W-1:0]  COOL_RESET  = 9'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH   = 2'd0,
        CFG_RATIO_Q16       = 2'd1,
        CFG_COOLDOWN_FRAMES = 2'd2
    } cfg_idx_t;

    localparam logic [STATUS_W-1:0] STATUS_CLEAR      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ALARM      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SUPPRESSED = 2'd2;

    typedef struct packed {
        logic [WLEN_W-1:0]  window_length;
        logic [RATIO_W-1:0] ratio_q16;
        logic [COOL_W-1:0]  cooldown_frames;
    } cfg_t;

    typedef struct packed {
        logic               entry_valid;
        logic               has_member;
        logic [CLASS_W-1:0] member_class;
        logic               frame_end;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] frame_status;
        logic                alone_flag;
    } res_t;

endpackage

/* hdl/wpva_ring.sv */
// ----------------------------------------------------------------------------
// wpva_ring
// one-bit flag ring, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module wpva_ring #(
    parameter int WINDOW_MAX = wpva_pkg::WINDOW_MAX_DEF,
    parameter int ADDR_W     = $clog2(WINDOW_MAX)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic              wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic              rdata
);

    logic mem [WINDOW_MAX];
    logic rdata_reg;

    // read data follows a same-cycle write to the read address
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/wpva_vote.sv */
// ----------------------------------------------------------------------------
// wpva_vote
// per-frame person tally, voting window bookkeeping and cooldown
// ----------------------------------------------------------------------------
module wpva_vote #(
    parameter int WINDOW_MAX = wpva_pkg::WINDOW_MAX_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  wpva_pkg::cfg_t  cfg,
    input  logic           fire,
    input  wpva_pkg::item_t item,
    output logic           res_valid,
    output wpva_pkg::res_t  res
);

    import wpva_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_MAX);
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int PROD_W = CNT_W + RATIO_W;

    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [CNT_W-1:0]   ones_reg, ones_next;
    logic [ADDR_W-1:0]  oldest_reg, oldest_next;
    logic [COOL_W-1:0]  cool_reg, cool_next;
    logic [CNT_W-1:0]   eff_len_reg;
    logic [CNT_W-1:0]   thresh_reg;

    logic [CNT_W-1:0]   eff_len_c;
    logic [PROD_W-1:0]  prod_c;
    logic               counts_c;
    logic [TALLY_W-1:0] tally_sum_c;
    logic               alone_c;

    logic               ring_we;
    logic [ADDR_W-1:0]  ring_waddr;
    logic               ring_rdata;

    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {{(CNT_W + 1 - ADDR_W){1'b0}}, a} + {1'b0, b};
        if (s >= (CNT_W + 1)'(WINDOW_MAX))
        begin
            s = s - (CNT_W + 1)'(WINDOW_MAX);
        end
        return s[ADDR_W-1:0];
    endfunction

    // effective length and threshold, worked out from cfg and held in eff_len_reg and thresh_reg
    always_comb
    begin
        if (cfg.window_length == '0)
        begin
            eff_len_c = CNT_W'(1);
        end
        else if (int'(cfg.window_length) > WINDOW_MAX)
        begin
            eff_len_c = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len_c = CNT_W'(cfg.window_length);
        end
        prod_c = {{RATIO_W{1'b0}}, eff_len_c} * {{CNT_W{1'b0}}, cfg.ratio_q16};
    end

    assign counts_c = item.entry_valid && item.has_member && (item.member_class == '0);
    assign tally_sum_c = (counts_c && (tally_reg < TALLY_W'(2))) ? tally_reg + TALLY_W'(1)
                                                                 : tally_reg;
    assign alone_c = (tally_sum_c == TALLY_W'(1));

    always_comb
    begin
        tally_next  = tally_reg;
        fill_next   = fill_reg;
        ones_next   = ones_reg;
        oldest_next = oldest_reg;
        cool_next   = cool_reg;
        ring_we     = 1'b0;
        ring_waddr  = ring_add(oldest_reg, fill_reg);
        res_valid   = 1'b0;
        res.frame_status = STATUS_CLEAR;
        res.alone_flag   = alone_c;
        if (fire)
        begin
            if (!item.frame_end)
            begin
                tally_next = tally_sum_c;
            end
            else
            begin
                tally_next = '0;
                res_valid  = 1'b1;
                if (cool_reg != '0)
                begin
                    res.frame_status = STATUS_SUPPRESSED;
                    cool_next = cool_reg - COOL_W'(1);
                end
                else if (fill_reg < eff_len_reg)
                begin
                    ring_we   = 1'b1;
                    fill_next = fill_reg + CNT_W'(1);
                    ones_next = ones_reg + CNT_W'(alone_c);
                end
                else if (ones_reg >= thresh_reg)
                begin
                    res.frame_status = STATUS_ALARM;
                    fill_next   = '0;
                    ones_next   = '0;
                    oldest_next = '0;
                    cool_next   = cfg.cooldown_frames;
                end
                else
                begin
                    // oldest flag leaves, newest lands behind the held run
                    ring_we     = 1'b1;
                    ones_next   = ones_reg - CNT_W'(ring_rdata) + CNT_W'(alone_c);
                    oldest_next = ring_add(oldest_reg, CNT_W'(1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg   <= '0;
            fill_reg    <= '0;
            ones_reg    <= '0;
            oldest_reg  <= '0;
            cool_reg    <= '0;
            eff_len_reg <= '0;
            thresh_reg  <= '0;
        end
        else
        begin
            tally_reg   <= tally_next;
            fill_reg    <= fill_next;
            ones_reg    <= ones_next;
            oldest_reg  <= oldest_next;
            cool_reg    <= cool_next;
            eff_len_reg <= eff_len_c;
            thresh_reg  <= prod_c[CNT_W+RATIO_FRAC_W-1:RATIO_FRAC_W];
        end
    end

    // the read port tracks the slot that will be oldest next cycle
    wpva_ring #(
        .WINDOW_MAX (WINDOW_MAX),
        .ADDR_W     (ADDR_W)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (alone_c),
        .raddr (oldest_next),
        .rdata (ring_rdata)
    );

endmodule

/* hdl/windowed_presence_vote_alarm.sv */
// ----------------------------------------------------------------------------
// windowed_presence_vote_alarm
// sliding k-of-n lone-person vote with alarm and cooldown holdoff
// ----------------------------------------------------------------------------
// Tracklet entries enter on the s_ stream, one per beat; s_tlast marks the
// last beat of a frame. Each frame end gives one beat on the m_ stream with
// the frame status and alone flag; beats without s_tlast give none.
// One beat is taken every cycle while s_tready is high. A frame result
// passes the input register and then the output register before it shows
// on m_tvalid; the vote logic between them is combinational, and its window
// ring is written at most once per frame. When m_tready is low with a result
// held, the input register keeps taking non-final beats; a frame end waits
// there and s_tready drops until the held result is taken.
// Configuration writes on cfg_we are taken at once; the user must make them
// only while idle, as the block does not enforce it. Index 0 window length,
// 1 vote ratio in Q1.16, 2 cooldown frames. Reset clears the tally, window
// counters and cooldown and loads the default configuration; the ring needs
// no clearing, since only slots written since the last clear are read.
// ----------------------------------------------------------------------------
module windowed_presence_vote_alarm #(
    parameter int WINDOW_MAX = wpva_pkg::WINDOW_MAX_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [wpva_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wpva_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // entry_valid [0], has_member [1], member_class [17:2], zero pad [23:18]
    input  logic [wpva_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // frame_status [1:0], alone_flag [2], zero pad [7:3]
    output logic [wpva_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import wpva_pkg::*;

    cfg_t  cfg_reg;
    logic  s1_valid_reg;
    item_t s1_item_reg;
    logic  s1_adv;
    logic  fire;
    logic  res_valid;
    res_t  res;
    logic  out_valid_reg;
    res_t  out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length   <= WLEN_RESET;
            cfg_reg.ratio_q16       <= RATIO_RESET;
            cfg_reg.cooldown_frames <= COOL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_LENGTH:   cfg_reg.window_length   <= cfg_data[WLEN_W-1:0];
                CFG_RATIO_Q16:       cfg_reg.ratio_q16       <= cfg_data[RATIO_W-1:0];
                CFG_COOLDOWN_FRAMES: cfg_reg.cooldown_frames <= cfg_data[COOL_W-1:0];
                default:             ;
            endcase
        end
    end

    // a frame end can only leave the input register if the output slot frees
    assign s1_adv   = !(s1_item_reg.frame_end && out_valid_reg && !m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign fire     = s1_valid_reg && s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_item_reg.entry_valid  <= s_tdata[0];
            s1_item_reg.has_member   <= s_tdata[1];
            s1_item_reg.member_class <= s_tdata[CLASS_W+1:2];
            s1_item_reg.frame_end    <= s_tlast;
        end
    end

    wpva_vote #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_vote (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .fire      (fire),
        .item      (s1_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - STATUS_W - 1){1'b0}},
                       out_res_reg.alone_flag, out_res_reg.frame_status};

endmodule

/* hdl/wpva_checker.sv */
// ----------------------------------------------------------------------------
// wpva_checker
// port-level checks of the vote alarm, bound to the top level
// ----------------------------------------------------------------------------
`include "windowed_presence_vote_alarm_assert.svh"

module wpva_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [wpva_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import wpva_pkg::*;

    // only the three defined status codes leave the block
    `WPVA_ASSERT(a_status_known, !m_tvalid || m_tdata[STATUS_W-1:0] <= STATUS_SUPPRESSED)

    `WPVA_ASSERT(a_pad_zero, !m_tvalid || m_tdata[OUT_TDATA_W-1:STATUS_W+1] == '0)

    // with no result held the input side never stalls
    `WPVA_ASSERT(a_ready_when_drained, m_tvalid || s_tready)

    `WPVA_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind windowed_presence_vote_alarm wpva_checker u_wpva_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
